FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Each expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define A_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("same-cycle check failed");

// Next-cycle implication
`define A_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/ffal_pkg.sv
`timescale 1ns / 1ps
package ffal_pkg;

    localparam int DEF_MAX_RANGES  = 64;
    localparam int DEF_OFFSET_BITS = 32;
    localparam int CNT_W           = 32;
    localparam int ALIGN_W         = 17;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ZALIGN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_OPEN  = 2'd1,
        K_CLOSE = 2'd2
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic    start_op;
        logic    rd_scan;
        logic    latch;
        logic    div_step;
        logic    advance;
        logic    plan;
        logic    sh_rd;
        logic    sh_wr;
        logic    wr0;
        logic    wr1;
        logic    commit;
        t_status code;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_free;
        logic zero_cnt;
        logic zero_align;
        logic at_end;
        logic div_done;
        logic scan_more;
        logic needs_slot;
        logic full;
        logic sh_done;
    } t_stat;

endpackage

FILE: hw/rtl/ffal_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  ffal_pkg::t_stat  i_stat,
    output ffal_pkg::t_cmd   o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_CHK  = 11'b00000000010,
        S_RD   = 11'b00000000100,
        S_LAT  = 11'b00000001000,
        S_DIV  = 11'b00000010000,
        S_EVAL = 11'b00000100000,
        S_SHRD = 11'b00001000000,
        S_SHWR = 11'b00010000000,
        S_WR0  = 11'b00100000000,
        S_WR1  = 11'b01000000000,
        S_DONE = 11'b10000000000
    } t_state;

    t_state            r_state, n_state;
    ffal_pkg::t_status r_code, n_code;

    assign o_busy = (r_state != S_IDLE);

    // Sequence one request
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.start_op = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.zero_cnt) begin
                    n_code  = ffal_pkg::ST_OK;
                    n_state = S_DONE;
                end else if (!i_stat.is_free && i_stat.zero_align) begin
                    n_code  = ffal_pkg::ST_ZALIGN;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.at_end) begin
                    if (i_stat.is_free) begin
                        n_state = S_EVAL;
                    end else begin
                        n_code  = ffal_pkg::ST_NOFIT;
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_LAT;
                end
            end
            S_LAT: begin
                o_cmd.latch = 1'b1;
                n_state     = i_stat.is_free ? S_EVAL : S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EVAL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EVAL: begin
                if (i_stat.scan_more) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end else if (i_stat.needs_slot && i_stat.full) begin
                    n_code  = ffal_pkg::ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.plan = 1'b1;
                    n_code     = ffal_pkg::ST_OK;
                    n_state    = S_SHRD;
                end
            end
            S_SHRD: begin
                if (i_stat.sh_done) begin
                    n_state = S_WR0;
                end else begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_SHRD;
            end
            S_WR0: begin
                o_cmd.wr0 = 1'b1;
                n_state   = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr1 = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                o_cmd.code   = r_code;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ffal_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    `A_NEXT(a_accept_busy, i_start && !o_busy, o_busy)
    `A_NEXT(a_done_idle, r_state == S_DONE, r_state == S_IDLE)

endmodule

FILE: hw/rtl/ffal_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffal_dpath #(
    parameter int MAX_RANGES  = ffal_pkg::DEF_MAX_RANGES,
    parameter int OFFSET_BITS = ffal_pkg::DEF_OFFSET_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffal_pkg::t_cmd                     i_cmd,
    output ffal_pkg::t_stat                    o_stat,
    input  logic                               i_action,
    input  logic [ffal_pkg::CNT_W-1:0]         i_req_bytes,
    input  logic [ffal_pkg::ALIGN_W-1:0]       i_align,
    input  logic [OFFSET_BITS-1:0]             i_release_offset,
    input  logic                               i_cfg_we,
    input  logic [ffal_pkg::CNT_W-1:0]         i_cfg_data,
    output logic                               o_result_valid,
    output logic [1:0]                         o_status,
    output logic [OFFSET_BITS-1:0]             o_granted_offset,
    output logic [ffal_pkg::CNT_W-1:0]         o_used_bytes,
    output logic [ffal_pkg::CNT_W-1:0]         o_free_bytes,
    output logic [ffal_pkg::CNT_W-1:0]         o_live_allocations,
    output logic [$clog2(MAX_RANGES+1)-1:0]    o_range_count
);

    localparam int W  = OFFSET_BITS;
    localparam int LW = W + 1;
    localparam int AW = $clog2(MAX_RANGES);
    localparam int IW = $clog2(MAX_RANGES + 1);
    localparam int CN = ffal_pkg::CNT_W;
    localparam int AL = ffal_pkg::ALIGN_W;
    localparam int TW = ((W > AL) ? W : AL) + 1;
    localparam int CW = ((LW > CN) ? LW : CN) + 2;
    localparam int DW = $clog2(TW + 1);

    // Free-range store
    logic [W-1:0]  mem_s [MAX_RANGES];
    logic [LW-1:0] mem_l [MAX_RANGES];
    logic          r_e0_fresh;
    logic [W-1:0]  r_rd_s;
    logic [LW-1:0] r_rd_l;

    // Request word
    logic          r_act;
    logic [CN-1:0] r_cnt;
    logic [AL-1:0] r_align;
    logic [W-1:0]  r_off;

    // Scan state
    logic [IW-1:0] r_idx;
    logic [W-1:0]  r_s, r_prev_s;
    logic [LW-1:0] r_len, r_prev_l;

    // Remainder unit
    logic [TW-1:0] r_t, r_sh;
    logic [AL-1:0] r_rem;
    logic [DW-1:0] r_dcnt;
    logic [AL:0]   div_part;
    logic [AL-1:0] n_rem;

    // Plan
    ffal_pkg::t_kind r_kind, p_kind;
    logic [IW-1:0]   r_pos, p_pos, r_k;
    logic            r_w0_v, p_w0_v, r_w1_v, p_w1_v;
    logic [IW-1:0]   r_w0_a, p_w0_a, r_w1_a, p_w1_a;
    logic [W-1:0]    r_w0_s, p_w0_s, r_w1_s, p_w1_s;
    logic [LW-1:0]   r_w0_l, p_w0_l, r_w1_l, p_w1_l;
    logic [W-1:0]    r_grant_p;

    // Totals and result
    logic [CN-1:0] r_cap, r_used, r_out, n_used, n_out;
    logic [IW-1:0] r_held;
    logic          r_valid;
    logic [1:0]    r_status;
    logic [W-1:0]  r_grant;

    // Allocate fit terms
    logic [TW-1:0] aligned;
    logic [CW-1:0] gap_w, need, rest_w;
    logic          fits, gap_nz, rest_nz;
    logic [W-1:0]  new_start;
    // Free join terms
    logic [W-1:0]  fend, prev_end;
    logic          join_next, join_prev;
    logic          at_end, full, upd;

    // Memory port select
    logic          we;
    logic [AW-1:0] wa, ra;
    logic [W-1:0]  ws;
    logic [LW-1:0] wl;
    logic          re;
    logic [IW-1:0] k_dn, k_up;

    assign at_end = (r_idx == r_held);
    assign full   = (r_held == IW'(MAX_RANGES));
    assign upd    = (i_cmd.code == ffal_pkg::ST_OK) && (r_cnt != '0);

    assign aligned   = r_t - TW'(r_rem);
    assign gap_w     = CW'(aligned) - CW'(r_s);
    assign need      = gap_w + CW'(r_cnt);
    assign fits      = CW'(r_len) >= need;
    assign rest_w    = CW'(r_len) - need;
    assign gap_nz    = (gap_w != '0);
    assign rest_nz   = (rest_w != '0);
    assign new_start = W'(CW'(aligned) + CW'(r_cnt));

    assign fend      = W'(CW'(r_off) + CW'(r_cnt));
    assign prev_end  = W'(CW'(r_prev_s) + CW'(r_prev_l));
    assign join_next = !at_end && (fend == r_s);
    assign join_prev = (r_idx != '0) && (prev_end == r_off);

    // Restoring remainder step
    assign div_part = {r_rem, r_sh[TW-1]};
    assign n_rem    = (div_part >= {1'b0, r_align}) ? AL'(div_part - {1'b0, r_align})
                                                    : div_part[AL-1:0];

    // Status to controller
    always_comb begin
        o_stat            = '0;
        o_stat.is_free    = (r_act == ffal_pkg::ACT_FREE);
        o_stat.zero_cnt   = (r_cnt == '0);
        o_stat.zero_align = (r_align == '0);
        o_stat.at_end     = at_end;
        o_stat.div_done   = (r_dcnt == '0);
        o_stat.scan_more  = o_stat.is_free ? (!at_end && (r_s < r_off)) : !fits;
        o_stat.needs_slot = o_stat.is_free ? (!join_next && !join_prev)
                                           : (gap_nz && rest_nz);
        o_stat.full       = full;
        case (r_kind)
            ffal_pkg::K_OPEN:  o_stat.sh_done = (r_k == r_pos);
            ffal_pkg::K_CLOSE: o_stat.sh_done = ({1'b0, r_k} + 1'b1) >= {1'b0, r_held};
            default:           o_stat.sh_done = 1'b1;
        endcase
    end

    // Work out the list edit
    always_comb begin
        p_kind = ffal_pkg::K_NONE;
        p_pos  = r_idx;
        p_w0_v = 1'b0;
        p_w0_a = r_idx;
        p_w0_s = r_s;
        p_w0_l = r_len;
        p_w1_v = 1'b0;
        p_w1_a = r_idx + 1'b1;
        p_w1_s = new_start;
        p_w1_l = LW'(rest_w);
        if (r_act == ffal_pkg::ACT_ALLOC) begin
            if (gap_nz && rest_nz) begin
                p_kind = ffal_pkg::K_OPEN;
                p_w0_v = 1'b1;
                p_w0_l = LW'(gap_w);
                p_w1_v = 1'b1;
            end else if (rest_nz) begin
                p_w0_v = 1'b1;
                p_w0_s = new_start;
                p_w0_l = LW'(rest_w);
            end else if (gap_nz) begin
                p_w0_v = 1'b1;
                p_w0_l = LW'(gap_w);
            end else begin
                p_kind = ffal_pkg::K_CLOSE;
            end
        end else begin
            if (join_next && join_prev) begin
                p_kind = ffal_pkg::K_CLOSE;
                p_w0_v = 1'b1;
                p_w0_a = r_idx - 1'b1;
                p_w0_s = r_prev_s;
                p_w0_l = r_prev_l + LW'(r_cnt) + r_len;
            end else if (join_next) begin
                p_w0_v = 1'b1;
                p_w0_s = r_off;
                p_w0_l = r_len + LW'(r_cnt);
            end else if (join_prev) begin
                p_w0_v = 1'b1;
                p_w0_a = r_idx - 1'b1;
                p_w0_s = r_prev_s;
                p_w0_l = r_prev_l + LW'(r_cnt);
            end else begin
                p_kind = ffal_pkg::K_OPEN;
                p_w0_v = 1'b1;
                p_w0_s = r_off;
                p_w0_l = LW'(r_cnt);
            end
        end
    end

    // Select memory port
    assign k_dn = r_k - 1'b1;
    assign k_up = r_k + 1'b1;
    always_comb begin
        we = 1'b0;
        wa = '0;
        ws = r_rd_s;
        wl = r_rd_l;
        if (i_cfg_we) begin
            we = 1'b1;
            ws = '0;
            wl = LW'(i_cfg_data);
        end else if (i_cmd.sh_wr) begin
            we = 1'b1;
            wa = r_k[AW-1:0];
        end else if (i_cmd.wr0 && r_w0_v) begin
            we = 1'b1;
            wa = r_w0_a[AW-1:0];
            ws = r_w0_s;
            wl = r_w0_l;
        end else if (i_cmd.wr1 && r_w1_v) begin
            we = 1'b1;
            wa = r_w1_a[AW-1:0];
            ws = r_w1_s;
            wl = r_w1_l;
        end
        re = i_cmd.rd_scan || i_cmd.sh_rd;
        if (i_cmd.sh_rd) begin
            ra = (r_kind == ffal_pkg::K_OPEN) ? k_dn[AW-1:0] : k_up[AW-1:0];
        end else begin
            ra = r_idx[AW-1:0];
        end
    end

    // Range store, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_s[wa] <= ws;
            mem_l[wa] <= wl;
        end
        if (re) begin
            if (r_e0_fresh && (ra == '0)) begin
                r_rd_s <= '0;
                r_rd_l <= '0;
            end else begin
                r_rd_s <= mem_s[ra];
                r_rd_l <= mem_l[ra];
            end
        end
    end

    // Entry zero reads as empty until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_fresh <= 1'b1;
        end else if (we && (wa == '0)) begin
            r_e0_fresh <= 1'b0;
        end
    end

    // Request, scan, remainder and plan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_op) begin
            r_act   <= i_action;
            r_cnt   <= i_req_bytes;
            r_align <= i_align;
            r_off   <= i_release_offset;
            r_idx   <= '0;
        end
        if (i_cmd.latch) begin
            r_s    <= r_rd_s;
            r_len  <= r_rd_l;
            r_t    <= TW'(r_rd_s) + TW'(r_align) - 1'b1;
            r_sh   <= TW'(r_rd_s) + TW'(r_align) - 1'b1;
            r_rem  <= '0;
            r_dcnt <= DW'(TW);
        end
        if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_sh   <= {r_sh[TW-2:0], 1'b0};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.advance) begin
            r_idx    <= r_idx + 1'b1;
            r_prev_s <= r_s;
            r_prev_l <= r_len;
        end
        if (i_cmd.plan) begin
            r_pos     <= p_pos;
            r_k       <= (p_kind == ffal_pkg::K_OPEN) ? r_held : p_pos;
            r_w0_v    <= p_w0_v;
            r_w0_a    <= p_w0_a;
            r_w0_s    <= p_w0_s;
            r_w0_l    <= p_w0_l;
            r_w1_v    <= p_w1_v;
            r_w1_a    <= p_w1_a;
            r_w1_s    <= p_w1_s;
            r_w1_l    <= p_w1_l;
            r_grant_p <= W'(aligned);
        end
        if (i_cmd.sh_wr) begin
            r_k <= (r_kind == ffal_pkg::K_OPEN) ? k_dn : k_up;
        end
    end

    // Next totals
    always_comb begin
        logic [CN:0] sum;
        sum = {1'b0, r_used} + {1'b0, r_cnt};
        if (r_act == ffal_pkg::ACT_ALLOC) begin
            n_used = sum[CN] ? '1 : sum[CN-1:0];
            n_out  = (r_out != '1) ? r_out + 1'b1 : r_out;
        end else begin
            n_used = (r_used > r_cnt) ? r_used - r_cnt : '0;
            n_out  = (r_out != '0) ? r_out - 1'b1 : r_out;
        end
    end

    // Commit totals and result word; capacity write reinitialises
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= '0;
            r_used  <= '0;
            r_out   <= '0;
            r_held  <= IW'(1);
            r_valid <= 1'b0;
            r_kind  <= ffal_pkg::K_NONE;
        end else begin
            r_valid <= i_cmd.commit;
            if (i_cmd.plan) begin
                r_kind <= p_kind;
            end
            if (i_cfg_we) begin
                r_cap  <= i_cfg_data;
                r_used <= '0;
                r_out  <= '0;
                r_held <= IW'(1);
            end else if (i_cmd.commit && upd) begin
                r_used <= n_used;
                r_out  <= n_out;
                if (r_kind == ffal_pkg::K_OPEN) begin
                    r_held <= r_held + 1'b1;
                end else if (r_kind == ffal_pkg::K_CLOSE) begin
                    r_held <= r_held - 1'b1;
                end
            end
            if (i_cmd.start_op) begin
                r_kind <= ffal_pkg::K_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= i_cmd.code;
            r_grant  <= (upd && (r_act == ffal_pkg::ACT_ALLOC)) ? r_grant_p : '0;
        end
    end

    assign o_result_valid     = r_valid;
    assign o_status           = r_status;
    assign o_granted_offset   = r_grant;
    assign o_used_bytes       = r_used;
    assign o_free_bytes       = (r_cap > r_used) ? r_cap - r_used : '0;
    assign o_live_allocations = r_out;
    assign o_range_count      = r_held;

    `A_IMPL(a_held_bound, 1'b1, r_held <= IW'(MAX_RANGES))
    `A_NEXT(a_alloc_live, i_cmd.commit && upd && (r_act == ffal_pkg::ACT_ALLOC), r_out != '0)

endmodule

FILE: hw/rtl/first_fit_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Word
// request   in         start, busy               i_action, i_req_bytes, i_align,
//                                                i_release_offset
// result    out        o_result_valid (strobe)   o_status ... o_range_count
// capacity  in         i_cfg_valid, o_cfg_ready  i_cfg_data
//
// Allocate: each range scanned is read, latched and put through a bit-serial
// remainder for the alignment; entries then move on a split or removal, and the
// list writes and commit follow. Free: a sorted scan reads and latches each range,
// then entries move and the freed range is written. Zero-size requests and
// zero-alignment allocations finish without a scan. Each moved entry is read, then
// written, as the range memory read is registered. Reset is synchronous; no
// clearing pass is needed. The result strobe lasts one cycle and cannot be stalled.
module first_fit_free_list_allocator_core #(
    parameter int MAX_RANGES  = ffal_pkg::DEF_MAX_RANGES,
    parameter int OFFSET_BITS = ffal_pkg::DEF_OFFSET_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_action,
    input  logic [ffal_pkg::CNT_W-1:0]       i_req_bytes,
    input  logic [ffal_pkg::ALIGN_W-1:0]     i_align,
    input  logic [OFFSET_BITS-1:0]           i_release_offset,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ffal_pkg::CNT_W-1:0]       i_cfg_data,
    output logic                             o_result_valid,
    output logic [1:0]                       o_status,
    output logic [OFFSET_BITS-1:0]           o_granted_offset,
    output logic [ffal_pkg::CNT_W-1:0]       o_used_bytes,
    output logic [ffal_pkg::CNT_W-1:0]       o_free_bytes,
    output logic [ffal_pkg::CNT_W-1:0]       o_live_allocations,
    output logic [$clog2(MAX_RANGES+1)-1:0]  o_range_count
);

    ffal_pkg::t_cmd  cmd;
    ffal_pkg::t_stat stat;
    logic            cfg_we;

    // Take capacity writes only while idle
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    ffal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ffal_dpath #(
        .MAX_RANGES  (MAX_RANGES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_action           (i_action),
        .i_req_bytes        (i_req_bytes),
        .i_align            (i_align),
        .i_release_offset   (i_release_offset),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (i_cfg_data),
        .o_result_valid     (o_result_valid),
        .o_status           (o_status),
        .o_granted_offset   (o_granted_offset),
        .o_used_bytes       (o_used_bytes),
        .o_free_bytes       (o_free_bytes),
        .o_live_allocations (o_live_allocations),
        .o_range_count      (o_range_count)
    );

endmodule
